FILE: hdl/rle_pkg.sv
// Package for the literal/repeat run-length encoder.
// Holds the shared widths, constants and enum types; depends on nothing.
package rle_pkg;

  localparam int unsigned LITERAL_MAX_DEF = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam logic [COUNT_W-1:0] REPEAT_MAX = 8'd129;

  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_LEN_LSB = 0;
  localparam int unsigned OUT_BYTE_LSB = 8;
  localparam int unsigned OUT_BATCH_BIT = 16;
  localparam int unsigned OUT_STREAM_BIT = 17;

  localparam logic KIND_REPEAT = 1'b0;
  localparam logic KIND_LITERAL = 1'b1;

  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_LIT   = 2'd1,
    MODE_REP   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FLUSH  = 4'b0010,
    ST_REP    = 4'b0100,
    ST_SINGLE = 4'b1000
  } state_e;

endpackage

FILE: hdl/rle_literal_repeat_encoder.sv
// Top level of the literal/repeat run-length encoder; uses rle_pkg.
// An item causing no result leaves ready high; ready returns after its last result is loaded.
// A literal flush reads the byte store (registered read port) at one result per cycle while
// the output does not stall; repeat and single-byte records need no read of the store.
// Reset clears the run state, the sequencer and the output valid flag; the byte store is
// not cleared and needs no clearing pass, since only written entries are ever read.
module rle_literal_repeat_encoder
  import rle_pkg::*;
#(
  parameter int unsigned LITERAL_MAX = LITERAL_MAX_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] data_byte
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] run_length, [15:8] out_byte, [16] batch_end, [17] stream_end, [23:18] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // [0] run_kind
  output logic                   m_axis_tuser
);

  localparam int unsigned AW = $clog2(LITERAL_MAX);
  localparam int unsigned NW = $clog2(LITERAL_MAX + 1);

  logic [BYTE_W-1:0] mem [LITERAL_MAX];
  logic [BYTE_W-1:0] rdata_q;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [BYTE_W-1:0] prev_q;
  logic              last_q;
  logic              pend_q, pend_d;
  logic              rep_en_q, rep_en_d;
  logic              single_en_q, single_en_d;
  logic [COUNT_W-1:0] rep_len_q, rep_len_d;
  logic [BYTE_W-1:0] rep_byte_q, rep_byte_d;
  logic [NW-1:0]     flush_len_q, flush_len_d;
  logic [NW-1:0]     rd_left_q, rd_left_d;
  logic [NW-1:0]     ld_left_q, ld_left_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic              rv_q, rv_d;

  logic              ov_q, ov_d;
  logic              o_kind_q, o_kind_d;
  logic [COUNT_W-1:0] o_len_q, o_len_d;
  logic [BYTE_W-1:0] o_byte_q, o_byte_d;
  logic              o_rend_q, o_rend_d;
  logic              o_bend_q, o_bend_d;
  logic              o_send_q, o_send_d;

  logic              acc, ofree, load_mem, re;
  logic              we_now, we;
  logic [AW-1:0]     waddr_now, waddr;
  logic [BYTE_W-1:0] b_in;
  logic [COUNT_W-1:0] cnt_m1, cnt_p1;
  logic [NW-1:0]     lit_n;
  logic              lit_bend;
  state_e            after_flush, after_rep;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign b_in  = s_axis_tdata[BYTE_W-1:0];
  assign ofree = !ov_q || m_axis_tready;
  assign cnt_m1 = count_q - COUNT_W'(1);
  assign cnt_p1 = count_q + COUNT_W'(1);

  // Plan of one accepted byte: optional literal flush, optional repeat record, optional single byte.
  always_comb begin
    mode_d      = mode_q;
    count_d     = count_q;
    lit_n       = '0;
    rep_en_d    = 1'b0;
    rep_len_d   = count_q;
    rep_byte_d  = prev_q;
    single_en_d = 1'b0;
    we_now      = 1'b0;
    waddr_now   = '0;
    pend_d      = 1'b0;
    case (mode_q)
      MODE_LIT: begin
        if (prev_q == b_in) begin
          lit_n   = cnt_m1[NW-1:0];
          mode_d  = MODE_REP;
          count_d = COUNT_W'(2);
          if (s_axis_tlast) begin
            rep_en_d   = 1'b1;
            rep_len_d  = COUNT_W'(2);
            rep_byte_d = b_in;
          end
        end else if (count_q >= COUNT_W'(LITERAL_MAX)) begin
          lit_n       = count_q[NW-1:0];
          pend_d      = 1'b1;
          count_d     = COUNT_W'(1);
          single_en_d = s_axis_tlast;
        end else begin
          we_now    = 1'b1;
          waddr_now = count_q[AW-1:0];
          count_d   = cnt_p1;
          if (s_axis_tlast) begin
            lit_n = cnt_p1[NW-1:0];
          end
        end
      end
      MODE_REP: begin
        if (prev_q == b_in && count_q < REPEAT_MAX) begin
          count_d = cnt_p1;
          if (s_axis_tlast) begin
            rep_en_d  = 1'b1;
            rep_len_d = cnt_p1;
          end
        end else begin
          rep_en_d    = 1'b1;
          we_now      = 1'b1;
          mode_d      = MODE_LIT;
          count_d     = COUNT_W'(1);
          single_en_d = s_axis_tlast;
        end
      end
      default: begin
        we_now      = 1'b1;
        mode_d      = MODE_LIT;
        count_d     = COUNT_W'(1);
        single_en_d = s_axis_tlast;
      end
    endcase
    if (s_axis_tlast) begin
      mode_d  = MODE_EMPTY;
      count_d = '0;
    end
  end

  assign after_rep   = single_en_q ? ST_SINGLE : ST_IDLE;
  assign after_flush = rep_en_q ? ST_REP : after_rep;
  assign load_mem    = (state_q == ST_FLUSH) && rv_q && ofree;
  assign re          = (state_q == ST_FLUSH) && (rd_left_q != '0) && (!rv_q || load_mem);
  assign lit_bend    = !rep_en_q && !single_en_q;

  // Sequencer and output register.
  always_comb begin
    state_d   = state_q;
    rd_left_d = rd_left_q;
    ld_left_d = ld_left_q;
    rd_addr_d = rd_addr_q;
    rv_d      = rv_q;
    flush_len_d = flush_len_q;
    ov_d      = ov_q && !m_axis_tready;
    o_kind_d  = o_kind_q;
    o_len_d   = o_len_q;
    o_byte_d  = o_byte_q;
    o_rend_d  = o_rend_q;
    o_bend_d  = o_bend_q;
    o_send_d  = o_send_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          flush_len_d = lit_n;
          rd_left_d   = lit_n;
          ld_left_d   = lit_n;
          rd_addr_d   = '0;
          rv_d        = 1'b0;
          if (lit_n != '0) begin
            state_d = ST_FLUSH;
          end else if (rep_en_d) begin
            state_d = ST_REP;
          end else if (single_en_d) begin
            state_d = ST_SINGLE;
          end
        end
      end
      ST_FLUSH: begin
        if (re) begin
          rd_left_d = rd_left_q - NW'(1);
          rd_addr_d = rd_addr_q + AW'(1);
          rv_d      = 1'b1;
        end else if (load_mem) begin
          rv_d = 1'b0;
        end
        if (load_mem) begin
          ov_d      = 1'b1;
          o_kind_d  = KIND_LITERAL;
          o_len_d   = {{(COUNT_W-NW){1'b0}}, flush_len_q};
          o_byte_d  = rdata_q;
          o_rend_d  = (ld_left_q == NW'(1));
          o_bend_d  = (ld_left_q == NW'(1)) && lit_bend;
          o_send_d  = (ld_left_q == NW'(1)) && lit_bend && last_q;
          ld_left_d = ld_left_q - NW'(1);
          if (ld_left_q == NW'(1)) begin
            state_d = after_flush;
          end
        end
      end
      ST_REP: begin
        if (ofree) begin
          ov_d     = 1'b1;
          o_kind_d = KIND_REPEAT;
          o_len_d  = rep_len_q;
          o_byte_d = rep_byte_q;
          o_rend_d = 1'b1;
          o_bend_d = !single_en_q;
          o_send_d = !single_en_q && last_q;
          state_d  = after_rep;
        end
      end
      ST_SINGLE: begin
        if (ofree) begin
          ov_d     = 1'b1;
          o_kind_d = KIND_LITERAL;
          o_len_d  = COUNT_W'(1);
          o_byte_d = prev_q;
          o_rend_d = 1'b1;
          o_bend_d = 1'b1;
          o_send_d = last_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The byte that starts a literal after a full flush is written once the flush is done.
  assign we    = (acc && we_now) || (pend_q && state_q != ST_IDLE && state_d == ST_IDLE);
  assign waddr = acc ? waddr_now : '0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= acc ? b_in : prev_q;
    end
    if (re) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_EMPTY;
      count_q     <= '0;
      pend_q      <= 1'b0;
      rep_en_q    <= 1'b0;
      single_en_q <= 1'b0;
      rd_left_q   <= '0;
      ld_left_q   <= '0;
      rv_q        <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_left_q <= rd_left_d;
      ld_left_q <= ld_left_d;
      rv_q      <= rv_d;
      ov_q      <= ov_d;
      if (acc) begin
        mode_q      <= mode_d;
        count_q     <= count_d;
        pend_q      <= pend_d;
        rep_en_q    <= rep_en_d;
        single_en_q <= single_en_d;
      end else if (state_q != ST_IDLE && state_d == ST_IDLE) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    flush_len_q <= flush_len_d;
    o_kind_q    <= o_kind_d;
    o_len_q     <= o_len_d;
    o_byte_q    <= o_byte_d;
    o_rend_q    <= o_rend_d;
    o_bend_q    <= o_bend_d;
    o_send_q    <= o_send_d;
    if (acc) begin
      prev_q     <= b_in;
      last_q     <= s_axis_tlast;
      rep_len_q  <= rep_len_d;
      rep_byte_q <= rep_byte_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = o_rend_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_STREAM_BIT-1){1'b0}}, o_send_q, o_bend_q,
                          o_byte_q, o_len_q};

endmodule

FILE: hdl/rle_checker.sv
// Port-level checker for the literal/repeat run-length encoder, bound to the top level.
// Uses rle_pkg and watches only the top level's ports.
module rle_checker
  import rle_pkg::*;
#(
  parameter int unsigned LITERAL_MAX = LITERAL_MAX_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  logic [COUNT_W-1:0] len;
  assign len = m_axis_tdata[OUT_LEN_LSB +: COUNT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("Stalled output item changed.");

  a_stream_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_STREAM_BIT] |->
      m_axis_tdata[OUT_BATCH_BIT] && m_axis_tlast)
    else $error("Stream end without batch end and run end.");

  a_repeat_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_REPEAT) |->
      m_axis_tlast && (len >= COUNT_W'(2)) && (len <= REPEAT_MAX))
    else $error("Malformed repeat record.");

  a_literal_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LITERAL) |->
      (len >= COUNT_W'(1)) && (len <= COUNT_W'(LITERAL_MAX)))
    else $error("Literal length out of range.");

endmodule

bind rle_literal_repeat_encoder rle_checker #(.LITERAL_MAX(LITERAL_MAX)) u_rle_checker (.*);
